@@ hdl/pswl_pkg.sv @@
`timescale 1ns / 1ps
package pswl_pkg;

  localparam int unsigned ROW_W    = 60;
  localparam int unsigned COEF_W   = 20;
  localparam int unsigned RES_W    = 15;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SQ_STEPS = 64;
  localparam int unsigned DIV_STEPS = 32;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_W = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RES_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RES_Y = 3'd4;

  localparam logic [ROW_W-1:0] ROW_X_RST = 60'd65536;
  localparam logic [ROW_W-1:0] ROW_Y_RST = 60'd68719476736;
  localparam logic [ROW_W-1:0] ROW_W_RST = 60'd72057594037927936;
  localparam logic [RES_W-1:0] RES_RST   = 15'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic signed [31:0] CLIP_MAX = 32'sh7FFF_FFFF;
  localparam logic [31:0] DIST_POS_SAT = 32'h7FFF_FFFF;
  localparam logic [31:0] DIST_NEG_SAT = 32'h8000_0000;

  // Projected point and direction, signed Q16.16.
  typedef struct packed {
    logic signed [31:0] cpx;
    logic signed [31:0] cpy;
    logic signed [31:0] cpz;
    logic signed [31:0] cvx;
    logic signed [31:0] cvy;
    logic signed [31:0] cvz;
  } clip_t;

  // Flags that ride along with the divider.
  typedef struct packed {
    logic zero;
    logic neg;
    logic big;
  } div_flags_t;

  function automatic logic signed [COEF_W-1:0] coef(input logic [ROW_W-1:0] row,
                                                     input int unsigned k);
    coef = $signed(row[COEF_W*k +: COEF_W]);
  endfunction

  // Clamp to the symmetric range +-(2^31-1).
  function automatic logic signed [31:0] sat31(input logic signed [52:0] v);
    if (v > 53'(CLIP_MAX)) begin
      sat31 = CLIP_MAX;
    end else if (v < -53'(CLIP_MAX)) begin
      sat31 = -CLIP_MAX;
    end else begin
      sat31 = v[31:0];
    end
  endfunction

  function automatic logic [63:0] mag65(input logic signed [64:0] v);
    mag65 = v[64] ? 64'(-v) : 64'(v);
  endfunction

endpackage

@@ hdl/pswl_clip.sv @@
`timescale 1ns / 1ps
// Three-stage matrix transform of the point and the direction into clip space.
module pswl_clip (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [15:0]                  in_w,
  input  logic signed [31:0]           px,
  input  logic signed [31:0]           py,
  input  logic signed [31:0]           dx,
  input  logic signed [31:0]           dy,
  input  logic [pswl_pkg::ROW_W-1:0]   row_x,
  input  logic [pswl_pkg::ROW_W-1:0]   row_y,
  input  logic [pswl_pkg::ROW_W-1:0]   row_w,
  input  logic [pswl_pkg::RES_W-1:0]   res_x,
  input  logic [pswl_pkg::RES_W-1:0]   res_y,
  output logic                         out_vld,
  output logic [15:0]                  out_w,
  output pswl_pkg::clip_t              clip
);

  // Index 0..2 is the point through rows x, y, w; 3..5 the direction.
  logic signed [51:0] m0_r [6];
  logic signed [51:0] m1_r [6];
  logic signed [37:0] v_r  [6];
  logic [2:0]         vld_r;
  logic [15:0]        w1_r, w2_r, w3_r;
  pswl_pkg::clip_t    clip_r;

  logic [pswl_pkg::ROW_W-1:0] rows [3];
  logic signed [31:0]         ax [6];
  logic signed [31:0]         ay [6];
  logic signed [53:0]         sum [6];
  logic signed [53:0]         sx, sy;

  assign rows[0] = row_x;
  assign rows[1] = row_y;
  assign rows[2] = row_w;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax[i]   = px;
      ay[i]   = py;
      ax[i+3] = dx;
      ay[i+3] = dy;
    end
    for (int i = 0; i < 6; i++) begin
      sum[i] = 54'(m0_r[i]) + 54'(m1_r[i]);
      // The point carries w = 1.0, which adds column 2 of the row.
      if (i < 3) begin
        sum[i] = sum[i] + (54'(pswl_pkg::coef(rows[i], 2)) <<< 16);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        m0_r[i] <= 52'(pswl_pkg::coef(rows[i % 3], 0)) * 52'(ax[i]);
        m1_r[i] <= 52'(pswl_pkg::coef(rows[i % 3], 1)) * 52'(ay[i]);
        v_r[i]  <= sum[i][53:16];
      end
      w1_r <= in_w;
      w2_r <= w1_r;
      w3_r <= w2_r;
    end
  end

  // Half-resolution scaling of the x and y rows, floored, then clamped.
  logic signed [53:0] spx, spy, svx, svy;

  assign sx  = 54'($signed({1'b0, res_x}));
  assign sy  = 54'($signed({1'b0, res_y}));
  assign spx = 54'(v_r[0]) * sx;
  assign spy = 54'(v_r[1]) * sy;
  assign svx = 54'(v_r[3]) * sx;
  assign svy = 54'(v_r[4]) * sy;

  always_ff @(posedge clk) begin
    if (en) begin
      clip_r.cpx <= pswl_pkg::sat31(spx[53:1]);
      clip_r.cpy <= pswl_pkg::sat31(spy[53:1]);
      clip_r.cpz <= pswl_pkg::sat31(53'(v_r[2]));
      clip_r.cvx <= pswl_pkg::sat31(svx[53:1]);
      clip_r.cvy <= pswl_pkg::sat31(svy[53:1]);
      clip_r.cvz <= pswl_pkg::sat31(53'(v_r[5]));
    end
  end

  assign out_vld = vld_r[2];
  assign out_w   = w3_r;
  assign clip    = clip_r;

endmodule

@@ hdl/pswl_sqrt.sv @@
`timescale 1ns / 1ps
// Pipelined digit-by-digit integer square root, one result bit per stage.
module pswl_sqrt #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [127:0]      radicand,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [63:0]       root,
  output logic [SIDE_W-1:0] out_side
);

  logic [65:0]       rem_r  [pswl_pkg::SQ_STEPS];
  logic [63:0]       root_r [pswl_pkg::SQ_STEPS];
  logic [127:0]      n_r    [pswl_pkg::SQ_STEPS];
  logic [SIDE_W-1:0] side_r [pswl_pkg::SQ_STEPS];
  logic              vld_r  [pswl_pkg::SQ_STEPS];

  for (genvar k = 0; k < pswl_pkg::SQ_STEPS; k++) begin : g_step
    logic [65:0]       rem_in, sh, trial;
    logic [63:0]       root_in;
    logic [127:0]      n_in;
    logic [SIDE_W-1:0] s_in;
    logic              v_in, ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = radicand;
      assign s_in    = in_side;
      assign v_in    = in_vld;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign n_in    = n_r[k-1];
      assign s_in    = side_r[k-1];
      assign v_in    = vld_r[k-1];
    end

    // Bring down the next two radicand bits and try root*4+1.
    assign sh    = {rem_in[63:0], n_in[127-2*k -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
      if (en) begin
        rem_r[k]  <= ge ? sh - trial : sh;
        root_r[k] <= {root_in[62:0], ge};
        n_r[k]    <= n_in;
        side_r[k] <= s_in;
      end
    end
  end

  assign out_vld  = vld_r[pswl_pkg::SQ_STEPS-1];
  assign root     = root_r[pswl_pkg::SQ_STEPS-1];
  assign out_side = side_r[pswl_pkg::SQ_STEPS-1];

endmodule

@@ hdl/pswl_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider for the low 32 quotient bits, one bit per stage.
module pswl_div #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [77:0]       rem0,
  input  logic [31:0]       low,
  input  logic [77:0]       divisor,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [31:0]       quot,
  output logic [SIDE_W-1:0] out_side
);

  logic [77:0]       rem_r  [pswl_pkg::DIV_STEPS];
  logic [31:0]       q_r    [pswl_pkg::DIV_STEPS];
  logic [31:0]       low_r  [pswl_pkg::DIV_STEPS];
  logic [77:0]       d_r    [pswl_pkg::DIV_STEPS];
  logic [SIDE_W-1:0] side_r [pswl_pkg::DIV_STEPS];
  logic              vld_r  [pswl_pkg::DIV_STEPS];

  for (genvar j = 0; j < pswl_pkg::DIV_STEPS; j++) begin : g_step
    logic [77:0]       rem_in, d_in;
    logic [31:0]       q_in, low_in;
    logic [SIDE_W-1:0] s_in;
    logic              v_in, ge;
    logic [78:0]       sh;

    if (j == 0) begin : g_first
      assign rem_in = rem0;
      assign q_in   = '0;
      assign low_in = low;
      assign d_in   = divisor;
      assign s_in   = in_side;
      assign v_in   = in_vld;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign q_in   = q_r[j-1];
      assign low_in = low_r[j-1];
      assign d_in   = d_r[j-1];
      assign s_in   = side_r[j-1];
      assign v_in   = vld_r[j-1];
    end

    assign sh = {rem_in, low_in[31-j]};
    assign ge = sh >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= v_in;
      end
      if (en) begin
        rem_r[j]  <= ge ? 78'(sh - {1'b0, d_in}) : sh[77:0];
        q_r[j]    <= {q_in[30:0], ge};
        low_r[j]  <= low_in;
        d_r[j]    <= d_in;
        side_r[j] <= s_in;
      end
    end
  end

  assign out_vld  = vld_r[pswl_pkg::DIV_STEPS-1];
  assign quot     = q_r[pswl_pkg::DIV_STEPS-1];
  assign out_side = side_r[pswl_pkg::DIV_STEPS-1];

endmodule

@@ hdl/projected_stroke_width_to_local.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Handshake          Payload
// in_      slave      tvalid / tready    pixel_width, point_x, point_y, dir_x, dir_y
// out_     master     tvalid / tready    local_distance, result_status
// cfg_     write      cfg_we             cfg_addr selects the register, cfg_wdata
//
// One transfer is taken in every clock cycle unless a result waits on out_tready, and
// each result passes three transform stages, four stages of cross products, squares
// and wide sums, 64 square-root stages, two denominator stages, 32 divider stages and
// the output register. The square root and divider lengths set the latency.
// Reset is synchronous and active low; it clears every valid bit and restores the
// identity matrix with a 2x2 viewport. When a result waits on out_tready the whole
// pipeline holds, so nothing is dropped or repeated.
module projected_stroke_width_to_local (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [15:0] pixel_width, [47:16] point_x, [79:48] point_y,
  // [111:80] dir_x, [143:112] dir_y
  input  logic [143:0]                   in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] local_distance, [33:32] result_status, [39:34] zero
  output logic [39:0]                    out_tdata,
  input  logic                           cfg_we,
  input  logic [pswl_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [pswl_pkg::ROW_W-1:0]     cfg_wdata
);

  // Configuration registers. The user must change them only while the pipeline is empty; the block does not enforce it.
  logic [pswl_pkg::ROW_W-1:0] row_x_r, row_y_r, row_w_r;
  logic [pswl_pkg::RES_W-1:0] res_x_r, res_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r <= pswl_pkg::ROW_X_RST;
      row_y_r <= pswl_pkg::ROW_Y_RST;
      row_w_r <= pswl_pkg::ROW_W_RST;
      res_x_r <= pswl_pkg::RES_RST;
      res_y_r <= pswl_pkg::RES_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        pswl_pkg::REG_ROW_X: row_x_r <= cfg_wdata;
        pswl_pkg::REG_ROW_Y: row_y_r <= cfg_wdata;
        pswl_pkg::REG_ROW_W: row_w_r <= cfg_wdata;
        pswl_pkg::REG_RES_X: res_x_r <= cfg_wdata[pswl_pkg::RES_W-1:0];
        pswl_pkg::REG_RES_Y: res_y_r <= cfg_wdata[pswl_pkg::RES_W-1:0];
        default: ;
      endcase
    end
  end

  // Every stage advances together unless a finished result is held up.
  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Transform into clip space.
  logic            c_vld;
  logic [15:0]     c_w;
  pswl_pkg::clip_t clip;

  pswl_clip u_clip (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_tvalid),
    .in_w    (in_tdata[15:0]),
    .px      ($signed(in_tdata[47:16])),
    .py      ($signed(in_tdata[79:48])),
    .dx      ($signed(in_tdata[111:80])),
    .dy      ($signed(in_tdata[143:112])),
    .row_x   (row_x_r),
    .row_y   (row_y_r),
    .row_w   (row_w_r),
    .res_x   (res_x_r),
    .res_y   (res_y_r),
    .out_vld (c_vld),
    .out_w   (c_w),
    .clip    (clip)
  );

  // Cross products for zeta, and the two Pz products used by the ratio.
  logic signed [63:0] a_r, b_r, c_r, d_r, zz_r, pp_r;
  logic [15:0]        w4_r, w5_r, w6_r;
  logic [3:0]         vld_r;

  // Magnitudes of zeta and the Pz products.
  logic [63:0] zx_r, zy_r;
  logic [61:0] mzz_r, pz2_r;
  logic [63:0] mzz_full;

  assign mzz_full = pswl_pkg::mag65(65'(zz_r));

  // Partial products of the squares and of the width products.
  logic [63:0] xhh_r, xhl_r, xll_r, yhh_r, yhl_r, yll_r;
  logic [46:0] th_r, tl_r, nh_r, nl_r;

  // Sums that feed the square root.
  logic [127:0] sq_r;
  logic [77:0]  t_r, num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], c_vld};
    end
    if (en) begin
      a_r  <= 64'(clip.cvx) * 64'(clip.cpz);
      b_r  <= 64'(clip.cvz) * 64'(clip.cpx);
      c_r  <= 64'(clip.cvy) * 64'(clip.cpz);
      d_r  <= 64'(clip.cvz) * 64'(clip.cpy);
      zz_r <= 64'(clip.cpz) * 64'(clip.cvz);
      pp_r <= 64'(clip.cpz) * 64'(clip.cpz);
      w4_r <= c_w;

      zx_r  <= pswl_pkg::mag65(65'(a_r) - 65'(b_r));
      zy_r  <= pswl_pkg::mag65(65'(c_r) - 65'(d_r));
      mzz_r <= mzz_full[61:0];
      pz2_r <= pp_r[61:0];
      w5_r  <= w4_r;

      xhh_r <= 64'(zx_r[63:32]) * 64'(zx_r[63:32]);
      xhl_r <= 64'(zx_r[63:32]) * 64'(zx_r[31:0]);
      xll_r <= 64'(zx_r[31:0]) * 64'(zx_r[31:0]);
      yhh_r <= 64'(zy_r[63:32]) * 64'(zy_r[63:32]);
      yhl_r <= 64'(zy_r[63:32]) * 64'(zy_r[31:0]);
      yll_r <= 64'(zy_r[31:0]) * 64'(zy_r[31:0]);
      th_r  <= 47'(w5_r) * 47'(mzz_r[61:31]);
      tl_r  <= 47'(w5_r) * 47'(mzz_r[30:0]);
      nh_r  <= 47'(w5_r) * 47'(pz2_r[61:31]);
      nl_r  <= 47'(w5_r) * 47'(pz2_r[30:0]);
      w6_r  <= w5_r;

      sq_r  <= {xhh_r, 64'd0} + (128'(xhl_r) << 33) + 128'(xll_r)
             + {yhh_r, 64'd0} + (128'(yhl_r) << 33) + 128'(yll_r);
      t_r   <= (78'(th_r) << 31) + 78'(tl_r);
      num_r <= (78'(nh_r) << 31) + 78'(nl_r);
    end
  end

  // |zeta| by the pipelined root; the width terms travel alongside.
  logic        s_vld;
  logic [63:0] len;
  logic [77:0] s_t, s_num;

  pswl_sqrt #(
    .SIDE_W (156)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld_r[3]),
    .radicand (sq_r),
    .in_side  ({t_r, num_r}),
    .out_vld  (s_vld),
    .root     (len),
    .out_side ({s_t, s_num})
  );

  // Denominator |zeta| - W*|Pz*Vz|, as magnitude and sign, both in Q.40.
  logic [77:0] lz;
  logic        den_vld_r, den_zero_r, den_neg_r;
  logic [77:0] den_r;
  logic [93:0] n_r;

  assign lz = {6'd0, len, 8'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      den_vld_r <= 1'b0;
    end else if (en) begin
      den_vld_r <= s_vld;
    end
    if (en) begin
      den_zero_r <= lz == s_t;
      den_neg_r  <= lz < s_t;
      den_r      <= (lz < s_t) ? s_t - lz : lz - s_t;
      n_r        <= {s_num, 16'd0};
    end
  end

  // A quotient of 2^32 or more saturates whatever its sign, so only the low
  // 32 quotient bits go through the divider.
  logic                 chk_vld_r;
  logic [77:0]          chk_rem_r, chk_d_r;
  logic [31:0]          chk_low_r;
  pswl_pkg::div_flags_t chk_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r <= 1'b0;
    end else if (en) begin
      chk_vld_r <= den_vld_r;
    end
    if (en) begin
      chk_rem_r        <= 78'(n_r[93:32]);
      chk_low_r        <= n_r[31:0];
      chk_d_r          <= den_r;
      chk_flags_r.zero <= den_zero_r;
      chk_flags_r.neg  <= den_neg_r;
      chk_flags_r.big  <= 78'(n_r[93:32]) >= den_r;
    end
  end

  logic                 q_vld;
  logic [31:0]          quot;
  pswl_pkg::div_flags_t q_flags;

  pswl_div #(
    .SIDE_W ($bits(pswl_pkg::div_flags_t))
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (chk_vld_r),
    .rem0     (chk_rem_r),
    .low      (chk_low_r),
    .divisor  (chk_d_r),
    .in_side  (chk_flags_r),
    .out_vld  (q_vld),
    .quot     (quot),
    .out_side (q_flags)
  );

  // Output register: sign, saturation and the zero-denominator case.
  logic [31:0] dist_nxt, dist_r;
  logic [1:0]  status_nxt, status_r;

  always_comb begin
    if (q_flags.zero) begin
      dist_nxt   = pswl_pkg::DIST_POS_SAT;
      status_nxt = pswl_pkg::ST_ZERO;
    end else if (!q_flags.neg) begin
      if (q_flags.big || quot > pswl_pkg::DIST_POS_SAT) begin
        dist_nxt   = pswl_pkg::DIST_POS_SAT;
        status_nxt = pswl_pkg::ST_SAT;
      end else begin
        dist_nxt   = quot;
        status_nxt = pswl_pkg::ST_OK;
      end
    end else begin
      if (q_flags.big || quot > pswl_pkg::DIST_NEG_SAT) begin
        dist_nxt   = pswl_pkg::DIST_NEG_SAT;
        status_nxt = pswl_pkg::ST_SAT;
      end else begin
        dist_nxt   = 32'd0 - quot;
        status_nxt = pswl_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= q_vld;
    end
    if (en) begin
      dist_r   <= dist_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, status_r, dist_r};

  // A zero denominator always reports the positive limit.
  a_zero_value : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33:32] == pswl_pkg::ST_ZERO
      |-> out_tdata[31:0] == pswl_pkg::DIST_POS_SAT)
    else $error("zero denominator without positive limit");

  // A saturated result sits at one of the two limits.
  a_sat_value : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33:32] == pswl_pkg::ST_SAT
      |-> out_tdata[31:0] == pswl_pkg::DIST_POS_SAT
       || out_tdata[31:0] == pswl_pkg::DIST_NEG_SAT)
    else $error("saturated result off the limits");

  // Reset empties the pipeline, so no result follows it directly.
  a_reset_empty : assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result present right after reset");

endmodule

@@ test/pswl_checker.sv @@
`timescale 1ns / 1ps
// Watches the three ports of the block, keeps its own copy of the matrix and
// viewport registers, predicts one result per input transfer and compares the
// results in order.
module pswl_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [143:0]                   in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [39:0]                    out_tdata,
  input  logic                           cfg_we,
  input  logic [pswl_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [pswl_pkg::ROW_W-1:0]     cfg_wdata,
  output int                             err_count,
  output int                             pending
);

  typedef struct {
    logic [31:0] value;
    logic [1:0]  status;
  } distance_t;

  distance_t expected_dist[$];

  logic [pswl_pkg::ROW_W-1:0] row_x, row_y, row_w;
  logic [pswl_pkg::RES_W-1:0] res_x, res_y;

  function automatic longint project(input logic [pswl_pkg::ROW_W-1:0] row, input longint x,
                                     input longint y, input longint w1,
                                     input logic [pswl_pkg::RES_W-1:0] res,
                                     input bit scaled);
    longint s;
    longint v;
    s = longint'($signed(row[19:0])) * x + longint'($signed(row[39:20])) * y +
        longint'($signed(row[59:40])) * w1;
    v = s >>> 16;
    if (scaled) begin
      v = (v * longint'({1'b0, res})) >>> 1;
    end
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
    end else if (v < -64'sd2147483647) begin
      v = -64'sd2147483647;
    end
    return v;
  endfunction

  function automatic logic [63:0] abs64(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [127:0] root_floor(input logic [127:0] n);
    logic [127:0] acc;
    logic [127:0] bitv;
    acc  = '0;
    bitv = 128'd1 << 126;
    for (int i = 0; i < 64; i++) begin
      if (n >= acc + bitv) begin
        n   = n - (acc + bitv);
        acc = (acc >> 1) + bitv;
      end else begin
        acc = acc >> 1;
      end
      bitv = bitv >> 2;
    end
    return acc;
  endfunction

  function automatic distance_t stroke_distance(input logic [143:0] d);
    distance_t r;
    logic [127:0] w, zx, zy, len, lz, t, den, num, q;
    longint px, py, dx, dy, cpx, cpy, cpz, cvx, cvy, cvz;
    w   = 128'(d[15:0]);
    px  = longint'($signed(d[47:16]));
    py  = longint'($signed(d[79:48]));
    dx  = longint'($signed(d[111:80]));
    dy  = longint'($signed(d[143:112]));
    cpx = project(row_x, px, py, 65536, res_x, 1'b1);
    cpy = project(row_y, px, py, 65536, res_y, 1'b1);
    cpz = project(row_w, px, py, 65536, '0, 1'b0);
    cvx = project(row_x, dx, dy, 0, res_x, 1'b1);
    cvy = project(row_y, dx, dy, 0, res_y, 1'b1);
    cvz = project(row_w, dx, dy, 0, '0, 1'b0);
    zx  = 128'(abs64(cvx * cpz - cvz * cpx));
    zy  = 128'(abs64(cvy * cpz - cvz * cpy));
    len = root_floor(zx * zx + zy * zy);
    lz  = len << 8;
    t   = w * 128'(abs64(cpz * cvz));
    if (lz == t) begin
      r.value  = pswl_pkg::DIST_POS_SAT;
      r.status = pswl_pkg::ST_ZERO;
      return r;
    end
    den = (lz > t) ? lz - t : t - lz;
    num = (w * 128'(64'(cpz * cpz))) << 16;
    q   = num / den;
    if (lz > t) begin
      if (q > 128'h7FFF_FFFF) begin
        r.value  = pswl_pkg::DIST_POS_SAT;
        r.status = pswl_pkg::ST_SAT;
      end else begin
        r.value  = q[31:0];
        r.status = pswl_pkg::ST_OK;
      end
    end else begin
      if (q > 128'h8000_0000) begin
        r.value  = pswl_pkg::DIST_NEG_SAT;
        r.status = pswl_pkg::ST_SAT;
      end else begin
        r.value  = -q[31:0];
        r.status = pswl_pkg::ST_OK;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    distance_t want;
    if (!rst_n) begin
      row_x     <= pswl_pkg::ROW_X_RST;
      row_y     <= pswl_pkg::ROW_Y_RST;
      row_w     <= pswl_pkg::ROW_W_RST;
      res_x     <= pswl_pkg::RES_RST;
      res_y     <= pswl_pkg::RES_RST;
      err_count <= 0;
      expected_dist.delete();
      pending   <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          pswl_pkg::REG_ROW_X: row_x <= cfg_wdata;
          pswl_pkg::REG_ROW_Y: row_y <= cfg_wdata;
          pswl_pkg::REG_ROW_W: row_w <= cfg_wdata;
          pswl_pkg::REG_RES_X: res_x <= cfg_wdata[pswl_pkg::RES_W-1:0];
          pswl_pkg::REG_RES_Y: res_y <= cfg_wdata[pswl_pkg::RES_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        expected_dist.push_back(stroke_distance(in_tdata));
      end
      if (out_tvalid && out_tready) begin
        if (expected_dist.size() == 0) begin
          if (err_count < 10) begin
            $display("unexpected result transfer: data %h", out_tdata);
          end
          err_count <= err_count + 1;
        end else begin
          want = expected_dist.pop_front();
          if (out_tdata[31:0] !== want.value || out_tdata[33:32] !== want.status) begin
            if (err_count < 10) begin
              $display("result wrong: distance %h status %0d, wanted %h status %0d",
                       out_tdata[31:0], out_tdata[33:32], want.value, want.status);
            end
            err_count <= err_count + 1;
          end
        end
      end
      pending <= expected_dist.size();
    end
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Top of the bench: drives configuration writes and input transfers, applies
// backpressure on the result side and reports the verdict. All checking lives
// in pswl_checker.
module testbench;

  // An index past the register list; the block must ignore writes to it.
  localparam logic [pswl_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT  = 600000;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [143:0]                   in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [39:0]                    out_tdata;
  logic                           cfg_we;
  logic [pswl_pkg::CFG_IDX_W-1:0] cfg_addr;
  logic [pswl_pkg::ROW_W-1:0]     cfg_wdata;
  int                             err_count;
  int                             pending;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int cycle_count;

  projected_stroke_width_to_local u_dut (.*);

  pswl_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A hung pipeline must still end the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("projected_stroke_width_to_local: mismatch");
      $finish;
    end
  end

  // Receiver. A long hold-off, when requested, overrides the random stalls so
  // that the pipeline fills and in_tready must drop.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [pswl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pswl_pkg::ROW_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_vertex(input logic [15:0] w, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] dx,
                             input logic [31:0] dy);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {dy, dx, py, px, w};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Coordinates: mostly modest magnitudes so divisions stay meaningful,
  // sometimes the full 32-bit range.
  function automatic logic [31:0] coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  task automatic random_vertices(input int count);
    logic [15:0] w;
    for (int i = 0; i < count; i++) begin
      w = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4096));
      send_vertex(w, coord(), coord(), coord(), coord());
    end
    in_tvalid <= 1'b0;
  endtask

  // Waits for every result, then lets any item still inside the pipeline out.
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Random matrix with moderate coefficients, w row kept mostly near one.
  function automatic logic [pswl_pkg::ROW_W-1:0] mild_row();
    logic [19:0] c0, c1, c2;
    c0 = 20'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    c1 = 20'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    c2 = 20'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    return {c2, c1, c0};
  endfunction

  task automatic set_config(input int which);
    case (which)
      0: begin
        write_reg(pswl_pkg::REG_ROW_X, pswl_pkg::ROW_X_RST);
        write_reg(pswl_pkg::REG_ROW_Y, pswl_pkg::ROW_Y_RST);
        write_reg(pswl_pkg::REG_ROW_W, pswl_pkg::ROW_W_RST);
        write_reg(pswl_pkg::REG_RES_X, 60'd1920);
        write_reg(pswl_pkg::REG_RES_Y, 60'd1080);
      end
      1: begin
        write_reg(pswl_pkg::REG_ROW_X, mild_row());
        write_reg(pswl_pkg::REG_ROW_Y, mild_row());
        write_reg(pswl_pkg::REG_ROW_W,
                  60'({20'h10000, mild_row() & 60'h00000_FFFFF_FFFFF} >> 20));
        write_reg(pswl_pkg::REG_RES_X, 60'd1);
        write_reg(pswl_pkg::REG_RES_Y, 60'd16384);
      end
      2: begin
        // Coefficient extremes and out-of-range resolutions.
        write_reg(pswl_pkg::REG_ROW_X, {20'h7FFFF, 20'h80000, 20'h7FFFF});
        write_reg(pswl_pkg::REG_ROW_Y, {20'h80000, 20'h7FFFF, 20'h80000});
        write_reg(pswl_pkg::REG_ROW_W, {20'h7FFFF, 20'h00001, 20'h80000});
        write_reg(pswl_pkg::REG_RES_X, 60'h7FFF);
        write_reg(pswl_pkg::REG_RES_Y, 60'd0);
      end
      default: begin
        write_reg(pswl_pkg::REG_ROW_X, 60'({$urandom, $urandom}));
        write_reg(pswl_pkg::REG_ROW_Y, 60'({$urandom, $urandom}));
        write_reg(pswl_pkg::REG_ROW_W, 60'({$urandom, $urandom}));
        write_reg(pswl_pkg::REG_RES_X, 60'(15'($urandom)));
        write_reg(pswl_pkg::REG_RES_Y, 60'(15'($urandom)));
      end
    endcase
    write_reg(REG_UNUSED, 60'({$urandom, $urandom}));
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = '0;
    cfg_wdata      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    cycle_count    = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part on the reset identity matrix and 2x2 viewport.
    send_vertex(16'd0, 32'd0, 32'd0, 32'd0, 32'd0);                 // no width, no zeta
    send_vertex(16'd256, 32'd0, 32'd0, 32'd0, 32'd0);               // zeta zero
    send_vertex(16'hFFFF, 32'h0001_0000, 32'h0, 32'h1, 32'h0);      // quotient overflow
    send_vertex(16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vertex(16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(16'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000);
    send_vertex(16'd256, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0);
    send_vertex(16'h8000, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0000_8000);
    send_vertex(16'h5555, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_vertex(16'hAAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    in_tvalid <= 1'b0;
    drain();

    // A perspective-like w row makes Pz*Vz nonzero, so the denominator can
    // cancel or go negative.
    write_reg(pswl_pkg::REG_ROW_W, {20'h10000, 20'h08000, 20'h08000});
    send_vertex(16'd0, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    send_vertex(16'h0100, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_vertex(16'hFFFF, 32'h0004_0000, 32'h0, 32'h0010_0000, 32'h0);
    send_vertex(16'h0400, 32'hFFFE_0000, 32'h0001_0000, 32'hFFF0_0000, 32'h0008_0000);
    in_tvalid <= 1'b0;
    drain();

    for (int cfg = 0; cfg < 4; cfg++) begin
      set_config(cfg);
      for (int phase = 0; phase < 4; phase++) begin
        case (phase)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
          default: begin send_idle_pct = 6; recv_stall_pct = 6; end
        endcase
        // Back up the whole pipeline once while the sender keeps offering.
        if (cfg == 1 && phase == 0) begin
          hold_cycles <= 400;
        end
        random_vertices(86);
      end
      drain();
    end

    if (err_count == 0) begin
      $display("projected_stroke_width_to_local: match");
    end else begin
      $display("projected_stroke_width_to_local: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/pswl_pkg.sv
hdl/pswl_clip.sv
hdl/pswl_sqrt.sv
hdl/pswl_div.sv
hdl/projected_stroke_width_to_local.sv
test/pswl_checker.sv
test/testbench.sv
